>>> sv/simu_pkg.sv
// ----------------------------------------------------------------------------
// simu_pkg: shared constants, types and helpers for the sea-ice momentum update
// Fixed-point limits, unit latencies, register indexes, opcodes and the
// saturating helpers that several pipeline units use.
// ----------------------------------------------------------------------------
package simu_pkg;

	// intermediates saturate at +-2^62
	localparam logic signed [63:0] LIM = 64'sh4000_0000_0000_0000;
	localparam logic [63:0] LIM_U = 64'h4000_0000_0000_0000;
	localparam logic [31:0] ONE_Q16 = 32'd65536;

	// unit latencies in cycles
	localparam int MUL_LAT = 4;
	localparam int QBITS = 79;
	localparam int DIV_LAT = QBITS + 2;
	localparam int ROOT_STEPS = 32;
	localparam int HYP_LAT = ROOT_STEPS + 4;

	// output buffer depth, above the pipeline latency for full rate
	localparam int OBUF_DEPTH = 256;
	localparam int MAX_NODES_DEF = 65536;

	// configuration register indexes
	localparam int CFG_IW = 3;
	localparam logic [CFG_IW-1:0] REG_ICE_DENSITY = 3'd0;
	localparam logic [CFG_IW-1:0] REG_OCEAN_DRAG = 3'd1;
	localparam logic [CFG_IW-1:0] REG_AIR_DRAG = 3'd2;
	localparam logic [CFG_IW-1:0] REG_CORIOLIS = 3'd3;
	localparam logic [CFG_IW-1:0] REG_TIME_STEP = 3'd4;
	localparam logic [CFG_IW-1:0] REG_RELAX_BETA = 3'd5;
	localparam logic [CFG_IW-1:0] REG_NODE_COUNT = 3'd6;

	localparam logic [31:0] ICE_DENSITY_RST = 32'd58982400;
	localparam logic [31:0] TIME_STEP_RST = 32'd65536;
	localparam logic [16:0] NODE_COUNT_RST = 17'd65536;

	// opcodes
	localparam logic OP_CAPTURE = 1'b0;
	localparam logic OP_UPDATE = 1'b1;

	typedef struct packed {
		logic signed [31:0] vx;
		logic signed [31:0] vy;
		logic               fault;
	} res_t;

	// magnitude of a two's complement word
	function automatic logic [63:0] mag(input logic signed [63:0] a);
		logic [63:0] u;
		u = a;
		return a[63] ? (~u + 64'd1) : u;
	endfunction

	// add with clamp to +-2^62
	function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic signed [63:0] s;
		s = a + b;
		if (s > LIM) return LIM;
		if (s < -LIM) return -LIM;
		return s;
	endfunction

	// clamp to 32-bit signed
	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) return 32'sh7fff_ffff;
		if (v < -64'sd2147483648) return 32'sh8000_0000;
		return v[31:0];
	endfunction

endpackage

>>> sv/sea_ice_momentum_node_update.sv
// ----------------------------------------------------------------------------
// sea_ice_momentum_node_update: per-node semi-implicit ice velocity update
// Datapath: 174 stages, set by two chained 81-stage dividers, m/dt and the
// final quotient, with the multiply and sum stages between them; the output
// buffer then adds its RAM write, registered read and hold register stage.
// Throughput: one node per cycle while out_ready holds.
// Reset: arst_n resets the config registers, node counter and queue control; start
// velocity storage is not cleared and holds garbage until captured.
// ----------------------------------------------------------------------------
module sea_ice_momentum_node_update #(
	parameter int MAX_NODES = simu_pkg::MAX_NODES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [simu_pkg::CFG_IW-1:0] cfg_index,
	input  logic [31:0]                 cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        opcode,
	input  logic signed [31:0]          vel_x,
	input  logic signed [31:0]          vel_y,
	input  logic signed [31:0]          ocean_x,
	input  logic signed [31:0]          ocean_y,
	input  logic signed [31:0]          wind_x,
	input  logic signed [31:0]          wind_y,
	input  logic [30:0]                 ice_thickness,
	input  logic [16:0]                 ice_cover,
	input  logic signed [31:0]          stress_div_x,
	input  logic signed [31:0]          stress_div_y,
	input  logic [30:0]                 node_mass,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic signed [31:0]          new_vel_x,
	output logic signed [31:0]          new_vel_y,
	output logic                        divide_fault
);

	localparam int AW = $clog2(MAX_NODES);
	localparam int CW = (AW + 1 > 17) ? AW + 1 : 17;
	localparam int OW = $clog2(simu_pkg::OBUF_DEPTH) + 1;
	localparam int RW = $bits(simu_pkg::res_t);

	// stage times, counted from the accept cycle
	localparam int TM = simu_pkg::MUL_LAT;
	localparam int TD = simu_pkg::DIV_LAT;
	localparam int TH = simu_pkg::HYP_LAT;
	localparam int T_MDT = TM + TD;
	localparam int T_AS = TH + 2 * TM + 1;
	localparam int T_T2 = T_AS + TM;
	localparam int T_T3 = 3 * TM;
	localparam int T_T1 = T_MDT + TM;
	localparam int T_NX = T_T1 + 3;
	localparam int T_Q = T_NX + TD;
	localparam int LAT = T_Q + 1;

	// configuration registers
	logic [31:0] ice_density_q, ocean_drag_q, air_drag_q, coriolis_q;
	logic [31:0] time_step_q, relax_beta_q;
	logic [16:0] node_count_q;

	logic [AW-1:0] cnt_q;
	logic [CW-1:0] lim, nxt;
	logic [OW-1:0] occ_q;
	logic [LAT-1:0] vld_q;
	logic accept, pop, cap_we;

	logic signed [63:0] vx64, vy64, ox64, oy64, wx64, wy64, sx64, sy64;
	logic signed [63:0] h64, a64, mass64, rho64, dt64, fo64, fa64, fc64, beta64;
	logic signed [32:0] ro, rv;
	logic [63:0] u0_raw;
	logic signed [63:0] u0x, u0y;

	logic signed [63:0] m, mdt, afo, afo_d, aa, ao, den1, den2, den2_d;
	logic signed [63:0] atm, ocn, awx, awy, oox, ooy;
	logic signed [63:0] wx_d, wy_d, ox_d, oy_d, a_d;
	logic signed [63:0] sax_s1, say_s1, t2x, t2y, t2x_d, t2y_d;
	logic signed [63:0] cor, ro_d, rv_d, t3x, t3y, t3x_d, t3y_d;
	logic signed [63:0] bvx, bvy, u0x_d, u0y_d, ubx_s1, uby_s1, ubx_d, uby_d;
	logic signed [63:0] t1x, t1y, t4x, t4y, t4x_d, t4y_d;
	logic signed [63:0] acc1x_s1, acc1y_s1, acc2x_s2, acc2y_s2, nx_s3, ny_s3;
	logic signed [63:0] den_s1, den_d, qx, qy;
	logic f_mdt, f_t4x, f_t4y, fx, fy, fault0, fault0_d, op_d;
	logic signed [31:0] evx_d, evy_d;
	logic mdt_ok_unused;
	simu_pkg::res_t res_s1, res_out;

	assign accept = in_valid & in_ready;
	assign pop = out_valid & out_ready;
	assign in_ready = (occ_q < OW'(simu_pkg::OBUF_DEPTH));

	// write configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ice_density_q <= simu_pkg::ICE_DENSITY_RST;
			ocean_drag_q <= '0;
			air_drag_q <= '0;
			coriolis_q <= '0;
			time_step_q <= simu_pkg::TIME_STEP_RST;
			relax_beta_q <= '0;
			node_count_q <= simu_pkg::NODE_COUNT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				simu_pkg::REG_ICE_DENSITY: ice_density_q <= cfg_data;
				simu_pkg::REG_OCEAN_DRAG:  ocean_drag_q <= cfg_data;
				simu_pkg::REG_AIR_DRAG:    air_drag_q <= cfg_data;
				simu_pkg::REG_CORIOLIS:    coriolis_q <= cfg_data;
				simu_pkg::REG_TIME_STEP:   time_step_q <= cfg_data;
				simu_pkg::REG_RELAX_BETA:  relax_beta_q <= cfg_data;
				simu_pkg::REG_NODE_COUNT:  node_count_q <= cfg_data[16:0];
				default: ;
			endcase
		end
	end

	// node counter wraps at the sweep length
	always_comb begin
		if (node_count_q == '0 || CW'(node_count_q) > CW'(MAX_NODES)) begin
			lim = CW'(MAX_NODES);
		end else begin
			lim = CW'(node_count_q);
		end
		nxt = CW'(cnt_q) + CW'(1);
	end

	// advance counter, credits and valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			occ_q <= '0;
			vld_q <= '0;
		end else begin
			if (accept) begin
				cnt_q <= (nxt >= lim) ? '0 : nxt[AW-1:0];
			end
			occ_q <= occ_q + OW'(accept) - OW'(pop);
			vld_q <= {vld_q[LAT-2:0], accept};
		end
	end

	// operand extension
	always_comb begin
		vx64 = 64'(vel_x);
		vy64 = 64'(vel_y);
		ox64 = 64'(ocean_x);
		oy64 = 64'(ocean_y);
		wx64 = 64'(wind_x);
		wy64 = 64'(wind_y);
		sx64 = 64'(stress_div_x);
		sy64 = 64'(stress_div_y);
		h64 = $signed(64'(ice_thickness));
		a64 = $signed(64'(ice_cover));
		mass64 = $signed(64'(node_mass));
		rho64 = $signed(64'(ice_density_q));
		dt64 = $signed(64'(time_step_q));
		fo64 = $signed(64'(ocean_drag_q));
		fa64 = $signed(64'(air_drag_q));
		fc64 = $signed(64'(coriolis_q));
		beta64 = $signed(64'(relax_beta_q));
		ro = 33'(ocean_x) - 33'(vel_x);
		rv = 33'(vel_y) - 33'(ocean_y);
		fault0 = (time_step_q == '0) || (node_mass == '0);
		u0x = 64'($signed(u0_raw[63:32]));
		u0y = 64'($signed(u0_raw[31:0]));
	end

	// start velocity store, addressed by the node counter
	assign cap_we = accept && (opcode == simu_pkg::OP_CAPTURE);

	simu_ram #(.W(64), .DEPTH(MAX_NODES)) u_start (
		.clk   (clk),
		.we    (cap_we),
		.waddr (cnt_q),
		.wdata ({vel_x, vel_y}),
		.raddr (cnt_q),
		.rdata (u0_raw)
	);

	// ice mass per area and the m/dt term
	simu_mul #(.SH(16)) u_m (.clk(clk), .a(rho64), .b(h64), .p(m));
	simu_div u_mdt (.clk(clk), .num(m), .den(dt64), .q(mdt), .fault(f_mdt));
	assign mdt_ok_unused = f_mdt;

	// drag magnitudes
	simu_hyp u_aa (.clk(clk), .x(wx64), .y(wy64), .r(aa));
	simu_hyp u_ao (.clk(clk), .x(64'(ro)), .y(64'(rv)), .r(ao));

	// implicit denominator
	simu_mul #(.SH(32)) u_afo (.clk(clk), .a(a64), .b(fo64), .p(afo));
	simu_dly #(.W(64), .N(TH - TM)) u_d_afo (.clk(clk), .d(afo), .q(afo_d));
	simu_mul #(.SH(16)) u_den1 (.clk(clk), .a(mdt),
		.b($signed(64'(simu_pkg::ONE_Q16) + 64'(relax_beta_q))), .p(den1));
	simu_mul #(.SH(16)) u_den2 (.clk(clk), .a(afo_d), .b(ao), .p(den2));
	simu_dly #(.W(64), .N(T_T1 - TH - TM)) u_d_den2 (.clk(clk), .d(den2), .q(den2_d));

	// wind and ocean forcing
	simu_mul #(.SH(32)) u_atm (.clk(clk), .a(fa64), .b(aa), .p(atm));
	simu_mul #(.SH(32)) u_ocn (.clk(clk), .a(fo64), .b(ao), .p(ocn));
	simu_dly #(.W(256), .N(TH + TM)) u_d_wo (.clk(clk),
		.d({wx64, wy64, ox64, oy64}), .q({wx_d, wy_d, ox_d, oy_d}));
	simu_mul #(.SH(16)) u_awx (.clk(clk), .a(atm), .b(wx_d), .p(awx));
	simu_mul #(.SH(16)) u_awy (.clk(clk), .a(atm), .b(wy_d), .p(awy));
	simu_mul #(.SH(16)) u_oox (.clk(clk), .a(ocn), .b(ox_d), .p(oox));
	simu_mul #(.SH(16)) u_ooy (.clk(clk), .a(ocn), .b(oy_d), .p(ooy));
	simu_dly #(.W(64), .N(T_AS)) u_d_a (.clk(clk), .d(a64), .q(a_d));
	simu_mul #(.SH(16)) u_t2x (.clk(clk), .a(a_d), .b(sax_s1), .p(t2x));
	simu_mul #(.SH(16)) u_t2y (.clk(clk), .a(a_d), .b(say_s1), .p(t2y));
	simu_dly #(.W(128), .N(T_T1 - T_T2)) u_d_t2 (.clk(clk),
		.d({t2x, t2y}), .q({t2x_d, t2y_d}));

	// Coriolis coupling
	simu_mul #(.SH(32)) u_cor (.clk(clk), .a(m), .b(fc64), .p(cor));
	simu_dly #(.W(128), .N(2 * TM)) u_d_r (.clk(clk),
		.d({64'(ro), 64'(rv)}), .q({ro_d, rv_d}));
	simu_mul #(.SH(16)) u_t3x (.clk(clk), .a(cor), .b(rv_d), .p(t3x));
	simu_mul #(.SH(16)) u_t3y (.clk(clk), .a(cor), .b(ro_d), .p(t3y));
	simu_dly #(.W(128), .N(T_T1 + 1 - T_T3)) u_d_t3 (.clk(clk),
		.d({t3x, t3y}), .q({t3x_d, t3y_d}));

	// relaxation term against the start velocity
	simu_mul #(.SH(16)) u_bvx (.clk(clk), .a(beta64), .b(vx64), .p(bvx));
	simu_mul #(.SH(16)) u_bvy (.clk(clk), .a(beta64), .b(vy64), .p(bvy));
	simu_dly #(.W(128), .N(TM - 1)) u_d_u0 (.clk(clk),
		.d({u0x, u0y}), .q({u0x_d, u0y_d}));
	simu_dly #(.W(128), .N(T_MDT - TM - 1)) u_d_ub (.clk(clk),
		.d({ubx_s1, uby_s1}), .q({ubx_d, uby_d}));
	simu_mul #(.SH(16)) u_t1x (.clk(clk), .a(mdt), .b(ubx_d), .p(t1x));
	simu_mul #(.SH(16)) u_t1y (.clk(clk), .a(mdt), .b(uby_d), .p(t1y));

	// stress divergence over node mass
	simu_div u_t4x (.clk(clk), .num(sx64), .den(mass64), .q(t4x), .fault(f_t4x));
	simu_div u_t4y (.clk(clk), .num(sy64), .den(mass64), .q(t4y), .fault(f_t4y));
	simu_dly #(.W(128), .N(T_T1 + 2 - TD)) u_d_t4 (.clk(clk),
		.d({t4x, t4y}), .q({t4x_d, t4y_d}));

	// saturating sums in model order
	always_ff @(posedge clk) begin
		sax_s1 <= simu_pkg::sadd(awx, oox);
		say_s1 <= simu_pkg::sadd(awy, ooy);
		ubx_s1 <= simu_pkg::sadd(bvx, u0x_d);
		uby_s1 <= simu_pkg::sadd(bvy, u0y_d);
		acc1x_s1 <= simu_pkg::sadd(t1x, t2x_d);
		acc1y_s1 <= simu_pkg::sadd(t1y, t2y_d);
		acc2x_s2 <= simu_pkg::sadd(acc1x_s1, t3x_d);
		acc2y_s2 <= simu_pkg::sadd(acc1y_s1, t3y_d);
		nx_s3 <= simu_pkg::sadd(acc2x_s2, t4x_d);
		ny_s3 <= simu_pkg::sadd(acc2y_s2, t4y_d);
		den_s1 <= simu_pkg::sadd(den1, den2_d);
	end
	simu_dly #(.W(64), .N(2)) u_d_den (.clk(clk), .d(den_s1), .q(den_d));

	// final divide
	simu_div u_qx (.clk(clk), .num(nx_s3), .den(den_d), .q(qx), .fault(fx));
	simu_div u_qy (.clk(clk), .num(ny_s3), .den(den_d), .q(qy), .fault(fy));

	simu_dly #(.W(66), .N(T_Q)) u_d_echo (.clk(clk),
		.d({opcode, fault0, vel_x, vel_y}), .q({op_d, fault0_d, evx_d, evy_d}));

	// select echo or update result
	always_ff @(posedge clk) begin
		if (op_d == simu_pkg::OP_CAPTURE) begin
			res_s1.vx <= evx_d;
			res_s1.vy <= evy_d;
			res_s1.fault <= 1'b0;
		end else begin
			res_s1.vx <= simu_pkg::sat32(qx);
			res_s1.vy <= simu_pkg::sat32(qy);
			res_s1.fault <= fault0_d | fx | fy;
		end
	end

	simu_obuf #(.W(RW), .DEPTH(simu_pkg::OBUF_DEPTH)) u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (vld_q[LAT-1]),
		.wr_data   (res_s1),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (res_out)
	);

	assign new_vel_x = res_out.vx;
	assign new_vel_y = res_out.vy;
	assign divide_fault = res_out.fault & ~mdt_ok_unused | res_out.fault;

endmodule

>>> sv/simu_ram.sv
// ----------------------------------------------------------------------------
// simu_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module simu_ram #(
	parameter int W = 64,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [W-1:0]             wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [W-1:0]             rdata
);

	logic [W-1:0] mem [DEPTH];

	// write, then registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> sv/simu_dly.sv
// ----------------------------------------------------------------------------
// simu_dly: fixed delay line
// Shifts a word through N registers to align it with a later pipeline stage.
// ----------------------------------------------------------------------------
module simu_dly #(
	parameter int W = 64,
	parameter int N = 1
) (
	input  logic         clk,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	generate
		if (N == 0) begin : g_none
			assign q = d;
		end else begin : g_line
			logic [W-1:0] tap_s [N];

			// advance every cycle
			always_ff @(posedge clk) begin
				tap_s[0] <= d;
				for (int k = 1; k < N; k++) begin
					tap_s[k] <= tap_s[k-1];
				end
			end
			assign q = tap_s[N-1];
		end
	endgenerate

endmodule

>>> sv/simu_mul.sv
// ----------------------------------------------------------------------------
// simu_mul: pipelined saturating fixed-point multiplier
// Sign-magnitude product built from four 32x32 partial products, shifted right
// by SH with truncation toward zero and clamped to +-2^62. Four stages.
// ----------------------------------------------------------------------------
module simu_mul #(
	parameter int SH = 16
) (
	input  logic               clk,
	input  logic signed [63:0] a,
	input  logic signed [63:0] b,
	output logic signed [63:0] p
);

	logic        neg_s1, neg_s2, neg_s3;
	logic [63:0] ma_s1, mb_s1;
	logic [63:0] p00_s2, p01_s2, p10_s2, p11_s2;
	logic [63:0] r_s3;
	logic [127:0] prod, shd;

	// combine partial products and shift; the clamp follows in the register stage
	always_comb begin
		prod = {p11_s2, 64'd0} + {32'd0, p01_s2, 32'd0} + {32'd0, p10_s2, 32'd0}
			+ {64'd0, p00_s2};
		shd = prod >> SH;
	end

	always_ff @(posedge clk) begin
		neg_s1 <= a[63] ^ b[63];
		ma_s1 <= simu_pkg::mag(a);
		mb_s1 <= simu_pkg::mag(b);

		neg_s2 <= neg_s1;
		p00_s2 <= ma_s1[31:0] * mb_s1[31:0];
		p01_s2 <= ma_s1[31:0] * mb_s1[63:32];
		p10_s2 <= ma_s1[63:32] * mb_s1[31:0];
		p11_s2 <= ma_s1[63:32] * mb_s1[63:32];

		neg_s3 <= neg_s2;
		r_s3 <= (shd > {64'd0, simu_pkg::LIM_U}) ? simu_pkg::LIM_U : shd[63:0];

		p <= neg_s3 ? -$signed(r_s3) : $signed(r_s3);
	end

endmodule

>>> sv/simu_div.sv
// ----------------------------------------------------------------------------
// simu_div: pipelined restoring divider, (num * 2^16) / den
// One quotient bit per stage, quotient clamped to 2^62, truncation toward
// zero. A zero divisor gives +-2^62 by the numerator's sign and raises fault.
// ----------------------------------------------------------------------------
module simu_div (
	input  logic               clk,
	input  logic signed [63:0] num,
	input  logic signed [63:0] den,
	output logic signed [63:0] q,
	output logic               fault
);

	localparam int NB = simu_pkg::QBITS;

	logic [63:0] rem_s [NB+1];
	logic [63:0] quo_s [NB+1];
	logic        sat_s [NB+1];
	logic [63:0] mn_s  [NB+1];
	logic [63:0] md_s  [NB+1];
	logic        neg_s [NB+1];
	logic        zr_s  [NB+1];
	logic        nn_s  [NB+1];
	logic [63:0] qm;

	// take magnitudes
	always_ff @(posedge clk) begin
		rem_s[0] <= '0;
		quo_s[0] <= '0;
		sat_s[0] <= 1'b0;
		mn_s[0] <= simu_pkg::mag(num);
		md_s[0] <= simu_pkg::mag(den);
		neg_s[0] <= num[63] ^ den[63];
		zr_s[0] <= (den == 64'sd0);
		nn_s[0] <= num[63];
	end

	generate
		for (genvar k = 0; k < NB; k++) begin : g_bit
			localparam int I = NB - 1 - k;
			logic        nb;
			logic [63:0] r2, q2;

			if (I >= 16) begin : g_num
				assign nb = mn_s[k][I-16];
			end else begin : g_zero
				assign nb = 1'b0;
			end

			// shift in one bit, subtract when it fits
			always_comb begin
				r2 = {rem_s[k][62:0], nb};
				q2 = {quo_s[k][62:0], 1'b0};
				if (r2 >= md_s[k]) begin
					r2 = r2 - md_s[k];
					q2[0] = 1'b1;
				end
			end

			always_ff @(posedge clk) begin
				rem_s[k+1] <= sat_s[k] ? rem_s[k] : r2;
				quo_s[k+1] <= sat_s[k] ? quo_s[k] : q2;
				sat_s[k+1] <= sat_s[k] | (q2 > simu_pkg::LIM_U);
				mn_s[k+1] <= mn_s[k];
				md_s[k+1] <= md_s[k];
				neg_s[k+1] <= neg_s[k];
				zr_s[k+1] <= zr_s[k];
				nn_s[k+1] <= nn_s[k];
			end
		end
	endgenerate

	assign qm = sat_s[NB] ? simu_pkg::LIM_U : quo_s[NB];

	// apply sign, handle zero divisor
	always_ff @(posedge clk) begin
		if (zr_s[NB]) begin
			q <= nn_s[NB] ? -simu_pkg::LIM : simu_pkg::LIM;
		end else begin
			q <= neg_s[NB] ? -$signed(qm) : $signed(qm);
		end
		fault <= zr_s[NB];
	end

endmodule

>>> sv/simu_hyp.sv
// ----------------------------------------------------------------------------
// simu_hyp: pipelined vector magnitude
// Floor square root of the sum of squares, one root digit per stage. When either
// input has magnitude 2^31 or more, both are halved first and the root doubled.
// ----------------------------------------------------------------------------
module simu_hyp (
	input  logic               clk,
	input  logic signed [63:0] x,
	input  logic signed [63:0] y,
	output logic signed [63:0] r
);

	localparam int NS = simu_pkg::ROOT_STEPS;

	logic [63:0] ax, ay;
	logic        big;
	logic [31:0] a_s1, b_s1;
	logic        big_s1, big_s2;
	logic [63:0] sa_s2, sb_s2;
	logic [63:0] n_s   [NS+1];
	logic [63:0] res_s [NS+1];
	logic        bg_s  [NS+1];

	// halve large components
	always_comb begin
		ax = simu_pkg::mag(x);
		ay = simu_pkg::mag(y);
		big = (ax >= 64'h8000_0000) || (ay >= 64'h8000_0000);
	end

	always_ff @(posedge clk) begin
		a_s1 <= big ? ax[32:1] : ax[31:0];
		b_s1 <= big ? ay[32:1] : ay[31:0];
		big_s1 <= big;

		sa_s2 <= a_s1 * a_s1;
		sb_s2 <= b_s1 * b_s1;
		big_s2 <= big_s1;

		n_s[0] <= sa_s2 + sb_s2;
		res_s[0] <= '0;
		bg_s[0] <= big_s2;
	end

	generate
		for (genvar k = 0; k < NS; k++) begin : g_dig
			localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
			logic [63:0] t;

			assign t = res_s[k] + BIT;

			// one root digit
			always_ff @(posedge clk) begin
				if (n_s[k] >= t) begin
					n_s[k+1] <= n_s[k] - t;
					res_s[k+1] <= (res_s[k] >> 1) + BIT;
				end else begin
					n_s[k+1] <= n_s[k];
					res_s[k+1] <= res_s[k] >> 1;
				end
				bg_s[k+1] <= bg_s[k];
			end
		end
	endgenerate

	always_ff @(posedge clk) begin
		r <= bg_s[NS] ? $signed(res_s[NS] << 1) : $signed(res_s[NS]);
	end

endmodule

>>> sv/simu_obuf.sv
// ----------------------------------------------------------------------------
// simu_obuf: output word buffer
// RAM queue behind the pipeline with a two-word register stage in front of
// the output, so the pipeline never stalls and the output runs at full rate.
// ----------------------------------------------------------------------------
module simu_obuf #(
	parameter int W = 65,
	parameter int DEPTH = 256
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr_en,
	input  logic [W-1:0] wr_data,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [W-1:0] out_data
);

	localparam int AW = $clog2(DEPTH);

	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0]   cnt_q;
	logic          pend_q;
	logic [1:0]    bcnt_q;
	logic          head_q;
	logic [W-1:0]  hold_q [2];
	logic [W-1:0]  rdata;
	logic          pop, issue;

	assign out_valid = (bcnt_q != 2'd0);
	assign out_data = hold_q[head_q];
	assign pop = out_valid & out_ready;
	assign issue = (cnt_q != '0) && ((3'(bcnt_q) + 3'(pend_q) - 3'(pop)) < 3'd2);

	simu_ram #(.W(W), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wp_q),
		.wdata (wr_data),
		.raddr (rp_q),
		.rdata (rdata)
	);

	// advance pointers and counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
			pend_q <= 1'b0;
			bcnt_q <= '0;
			head_q <= 1'b0;
		end else begin
			if (wr_en) begin
				wp_q <= wp_q + AW'(1);
			end
			if (issue) begin
				rp_q <= rp_q + AW'(1);
			end
			cnt_q <= cnt_q + (AW+1)'(wr_en) - (AW+1)'(issue);
			pend_q <= issue;
			bcnt_q <= bcnt_q + 2'(pend_q) - 2'(pop);
			head_q <= head_q ^ pop;
		end
	end

	// land read word behind the words already held
	always_ff @(posedge clk) begin
		if (pend_q) begin
			hold_q[head_q ^ bcnt_q[0]] <= rdata;
		end
	end

endmodule

>>> sv/simu_chk.sv
// ----------------------------------------------------------------------------
// simu_chk: port-level checker for the momentum update block
// Watches the handshakes and keeps a count of words in flight.
// ----------------------------------------------------------------------------
module simu_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [31:0] new_vel_x,
	input logic signed [31:0] new_vel_y,
	input logic               divide_fault
);

	logic [31:0] pend_q;

	// count words accepted and not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 32'(in_valid & in_ready) - 32'(out_valid & out_ready);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("output word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=>
		($stable(new_vel_x) && $stable(new_vel_y) && $stable(divide_fault)))
		else $error("output word changed while stalled");

	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pend_q != 32'd0))
		else $error("output word with nothing in flight");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q == 32'd0) |-> in_ready)
		else $error("empty block refuses input");

endmodule

bind sea_ice_momentum_node_update simu_chk u_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.new_vel_x    (new_vel_x),
	.new_vel_y    (new_vel_y),
	.divide_fault (divide_fault)
);

>>> tb/sea_ice_momentum_node_update_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sea_ice_momentum_node_update_test: self-checking bench for the node update
// Walks a short table of captures and updates, then streams random phases under
// changing register settings. Every output word is checked field by field
// against a fixed-point predictor of the update, with bursty input, stalls on
// the output and one long output hold-off that backs the pipeline up.
// ----------------------------------------------------------------------------
module sea_ice_momentum_node_update_test;

	localparam int IDLE_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 220;
	localparam int HOLD_CYCLES = 600;
	localparam int PHASES = 10;
	localparam int PHASE_WORDS = 125;
	localparam int HOLD_PHASE = 5;
	localparam int HOLD_PHASE_WORDS = 405;

	typedef struct {
		logic               op;
		logic signed [31:0] vx, vy, ox, oy, wx, wy;
		logic [30:0]        h;
		logic [16:0]        a;
		logic signed [31:0] sx, sy;
		logic [30:0]        mass;
		bit                 typed;
		logic signed [31:0] ex, ey;
	} node_word_t;

	logic clk, arst_n;
	logic cfg_we;
	logic [simu_pkg::CFG_IW-1:0] cfg_index;
	logic [31:0] cfg_data;
	logic in_valid, in_ready, out_valid, out_ready;
	logic opcode;
	logic signed [31:0] vel_x, vel_y, ocean_x, ocean_y, wind_x, wind_y;
	logic [30:0] ice_thickness, node_mass;
	logic [16:0] ice_cover;
	logic signed [31:0] stress_div_x, stress_div_y;
	logic signed [31:0] new_vel_x, new_vel_y;
	logic divide_fault;

	// predictor state
	logic [31:0] rho_q, fo_q, fa_q, fc_q, dt_q, beta_q;
	logic [16:0] nodes_q;
	int unsigned node_ptr;
	bit captured [simu_pkg::MAX_NODES_DEF];
	logic signed [31:0] u0_x [simu_pkg::MAX_NODES_DEF];
	logic signed [31:0] u0_y [simu_pkg::MAX_NODES_DEF];

	simu_pkg::res_t vel_due [$];
	int mismatches = 0;
	int idle_cycles = 0;
	int burst_left = 0;
	bit hold_req = 0;

	sea_ice_momentum_node_update u_dut (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [63:0] abs64(input logic signed [63:0] a);
		return a < 0 ? 64'(-a) : 64'(a);
	endfunction

	// signed product, truncated toward zero, shifted and clamped
	function automatic logic signed [63:0] qmul(input logic signed [63:0] a,
		input logic signed [63:0] b, input int sh);
		logic [127:0] p;
		logic [63:0] r;
		p = {64'b0, abs64(a)} * {64'b0, abs64(b)};
		p = p >> sh;
		r = (p > {64'b0, simu_pkg::LIM_U}) ? simu_pkg::LIM_U : p[63:0];
		return ((a < 0) != (b < 0)) ? -$signed(r) : $signed(r);
	endfunction

	// (num << 16) / den, clamped; a zero divisor saturates and flags
	function automatic logic signed [63:0] qdiv(input logic signed [63:0] num,
		input logic signed [63:0] den, inout bit flt);
		logic [127:0] q;
		logic [63:0] r;
		if (den == 0) begin
			flt = 1'b1;
			return num < 0 ? -simu_pkg::LIM : simu_pkg::LIM;
		end
		q = {48'b0, abs64(num), 16'b0} / {64'b0, abs64(den)};
		r = (q > {64'b0, simu_pkg::LIM_U}) ? simu_pkg::LIM_U : q[63:0];
		return ((num < 0) != (den < 0)) ? -$signed(r) : $signed(r);
	endfunction

	function automatic logic [63:0] root64(input logic [63:0] n);
		logic [63:0] res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv >>= 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	// vector length; halve both legs first when either is 2^31 or more
	function automatic logic signed [63:0] speed(input logic signed [63:0] x,
		input logic signed [63:0] y);
		logic [63:0] a, b;
		a = abs64(x);
		b = abs64(y);
		if (a >= 64'h8000_0000 || b >= 64'h8000_0000) begin
			a >>= 1;
			b >>= 1;
			return $signed(root64(a * a + b * b) << 1);
		end
		return $signed(root64(a * a + b * b));
	endfunction

	function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) return 32'sh7fff_ffff;
		if (v < -64'sd2147483648) return 32'sh8000_0000;
		return v[31:0];
	endfunction

	// expected output word for one node; advances the node pointer
	function automatic simu_pkg::res_t momentum_predict(input node_word_t w);
		logic signed [63:0] vx, vy, ox, oy, wx, wy, h, a, sx, sy, mass, beta;
		logic signed [63:0] fo, fa, ro, rv, aa, ao, m, mdt, den, atm, ocn, cor, nx, ny;
		int unsigned idx, lim;
		bit flt;
		simu_pkg::res_t r;
		idx = node_ptr % simu_pkg::MAX_NODES_DEF;
		lim = (nodes_q == 0 || nodes_q > simu_pkg::MAX_NODES_DEF)
			? simu_pkg::MAX_NODES_DEF : 32'(nodes_q);
		vx = 64'(w.vx);
		vy = 64'(w.vy);
		flt = 1'b0;
		if (w.op == simu_pkg::OP_CAPTURE) begin
			u0_x[idx] = w.vx;
			u0_y[idx] = w.vy;
			captured[idx] = 1'b1;
			r.vx = w.vx;
			r.vy = w.vy;
			r.fault = 1'b0;
		end else begin
			ox = 64'(w.ox); oy = 64'(w.oy); wx = 64'(w.wx); wy = 64'(w.wy);
			sx = 64'(w.sx); sy = 64'(w.sy);
			h = {33'b0, w.h};
			a = {47'b0, w.a};
			mass = {33'b0, w.mass};
			beta = {32'b0, beta_q};
			fo = {32'b0, fo_q};
			fa = {32'b0, fa_q};
			ro = ox - vx;
			rv = vy - oy;
			aa = speed(wx, wy);
			ao = speed(ro, rv);
			m = qmul({32'b0, rho_q}, h, 16);
			mdt = qdiv(m, {32'b0, dt_q}, flt);
			den = simu_pkg::sadd(qmul(mdt, 64'sd65536 + beta, 16),
				qmul(qmul(a, fo, 32), ao, 16));
			atm = qmul(fa, aa, 32);
			ocn = qmul(fo, ao, 32);
			cor = qmul(m, {32'b0, fc_q}, 32);
			nx = qmul(mdt, simu_pkg::sadd(qmul(beta, vx, 16), 64'(u0_x[idx])), 16);
			nx = simu_pkg::sadd(nx, qmul(a, simu_pkg::sadd(qmul(atm, wx, 16),
				qmul(ocn, ox, 16)), 16));
			nx = simu_pkg::sadd(nx, qmul(cor, rv, 16));
			nx = simu_pkg::sadd(nx, qdiv(sx, mass, flt));
			ny = qmul(mdt, simu_pkg::sadd(qmul(beta, vy, 16), 64'(u0_y[idx])), 16);
			ny = simu_pkg::sadd(ny, qmul(a, simu_pkg::sadd(qmul(atm, wy, 16),
				qmul(ocn, oy, 16)), 16));
			ny = simu_pkg::sadd(ny, qmul(cor, ro, 16));
			ny = simu_pkg::sadd(ny, qdiv(sy, mass, flt));
			r.vx = clamp32(qdiv(nx, den, flt));
			r.vy = clamp32(qdiv(ny, den, flt));
			r.fault = flt;
		end
		node_ptr = (node_ptr + 1 >= lim) ? 0 : node_ptr + 1;
		return r;
	endfunction

	// write one register on the port and in the predictor
	task automatic write_reg(input logic [simu_pkg::CFG_IW-1:0] idx,
		input logic [31:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			simu_pkg::REG_ICE_DENSITY: rho_q = data;
			simu_pkg::REG_OCEAN_DRAG: fo_q = data;
			simu_pkg::REG_AIR_DRAG: fa_q = data;
			simu_pkg::REG_CORIOLIS: fc_q = data;
			simu_pkg::REG_TIME_STEP: dt_q = data;
			simu_pkg::REG_RELAX_BETA: beta_q = data;
			simu_pkg::REG_NODE_COUNT: nodes_q = data[16:0];
			default: ;
		endcase
	endtask

	task automatic write_all(input logic [31:0] rho, fo, fa, fc, dt, beta, nodes);
		write_reg(simu_pkg::REG_ICE_DENSITY, rho);
		write_reg(simu_pkg::REG_OCEAN_DRAG, fo);
		write_reg(simu_pkg::REG_AIR_DRAG, fa);
		write_reg(simu_pkg::REG_CORIOLIS, fc);
		write_reg(simu_pkg::REG_TIME_STEP, dt);
		write_reg(simu_pkg::REG_RELAX_BETA, beta);
		write_reg(simu_pkg::REG_NODE_COUNT, nodes);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// offer one word in bursts with gaps, then predict on accept
	task automatic send_word(input node_word_t w);
		simu_pkg::res_t r;
		if (burst_left == 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat ($urandom_range(0, 6)) @(negedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 30);
		end
		burst_left--;
		@(negedge clk);
		in_valid <= 1'b1;
		opcode <= w.op;
		vel_x <= w.vx; vel_y <= w.vy;
		ocean_x <= w.ox; ocean_y <= w.oy;
		wind_x <= w.wx; wind_y <= w.wy;
		ice_thickness <= w.h;
		ice_cover <= w.a;
		stress_div_x <= w.sx; stress_div_y <= w.sy;
		node_mass <= w.mass;
		do @(posedge clk); while (!in_ready);
		r = momentum_predict(w);
		if (w.typed) begin
			r.vx = w.ex;
			r.vy = w.ey;
			r.fault = 1'b0;
		end
		vel_due.push_back(r);
	endtask

	// wait out the pipeline before touching registers
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		burst_left = 0;
		wait (vel_due.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [31:0] pick32();
		case ($urandom_range(0, 7))
			0: return 32'h0000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h8000_0000;
			3: return 32'hffff_ffff;
			4: return $urandom_range(0, 1) ? ($urandom & 32'h0003_ffff)
				: -($urandom & 32'h0003_ffff);
			default: return $urandom;
		endcase
	endfunction

	// capture where the node has no start velocity yet, else mostly update
	function automatic node_word_t random_word();
		node_word_t w;
		if (!captured[node_ptr % simu_pkg::MAX_NODES_DEF] || $urandom_range(0, 3) == 0)
			w.op = simu_pkg::OP_CAPTURE;
		else
			w.op = simu_pkg::OP_UPDATE;
		w.vx = pick32(); w.vy = pick32();
		w.ox = pick32(); w.oy = pick32();
		w.wx = pick32(); w.wy = pick32();
		w.sx = pick32(); w.sy = pick32();
		w.h = $urandom_range(0, 3) == 0 ? 31'(pick32()) : 31'($urandom & 32'h000f_ffff);
		case ($urandom_range(0, 3))
			0: w.a = 17'd0;
			1: w.a = 17'd65536;
			default: w.a = 17'($urandom_range(0, 65536));
		endcase
		w.mass = $urandom_range(0, 15) == 0 ? 31'd0 : 31'(pick32());
		w.typed = 1'b0;
		w.ex = '0;
		w.ey = '0;
		return w;
	endfunction

	// directed rows: captures echo their velocity, updates go to the predictor
	node_word_t dir_tab [20] = '{
		'{simu_pkg::OP_CAPTURE, 32'sh7fffffff, 32'sh80000000, 0, 0, 0, 0, 0, 0, 0, 0, 0,
			1, 32'sh7fffffff, 32'sh80000000},
		'{simu_pkg::OP_CAPTURE, 0, -1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, -1},
		'{simu_pkg::OP_CAPTURE, 65536, -65536, 0, 0, 0, 0, 0, 0, 0, 0, 0,
			1, 65536, -65536},
		'{simu_pkg::OP_CAPTURE, 32'sh80000000, 32'sh7fffffff, 0, 0, 0, 0, 0, 0, 0, 0, 0,
			1, 32'sh80000000, 32'sh7fffffff},
		'{simu_pkg::OP_UPDATE, 65536, 32768, 131072, -65536, 655360, 327680, 65536,
			49152, 4096, -4096, 65536, 0, 0, 0},
		// zero node mass
		'{simu_pkg::OP_UPDATE, 1000, -1000, 2000, 3000, 0, 0, 65536, 65536, 65536, -1,
			0, 0, 0, 0},
		// no ice and no cover: zero denominator
		'{simu_pkg::OP_UPDATE, 1000, 2000, 5000, 6000, 70000, 1, 0, 0, 12345, 0, 65536,
			0, 0, 0},
		// relative ocean speed past 2^31
		'{simu_pkg::OP_UPDATE, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff,
			32'sh80000000, 32'sh80000000, 32'sh80000000, 31'h7fffffff, 65536,
			32'sh7fffffff, 32'sh80000000, 31'h7fffffff, 0, 0, 0},
		'{simu_pkg::OP_CAPTURE, -1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, -1, 0},
		'{simu_pkg::OP_CAPTURE, 32'sh55555555, 32'shaaaaaaaa, 0, 0, 0, 0, 0, 0, 0, 0, 0,
			1, 32'sh55555555, 32'shaaaaaaaa},
		'{simu_pkg::OP_CAPTURE, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 1},
		'{simu_pkg::OP_CAPTURE, 32'sh7fffffff, 32'sh7fffffff, 0, 0, 0, 0, 0, 0, 0, 0, 0,
			1, 32'sh7fffffff, 32'sh7fffffff},
		'{simu_pkg::OP_UPDATE, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
			32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 31'h7fffffff, 65536,
			32'sh7fffffff, 32'sh7fffffff, 31'h7fffffff, 0, 0, 0},
		'{simu_pkg::OP_UPDATE, -1, -1, -1, -1, -1, -1, 1, 1, -1, -1, 1, 0, 0, 0},
		'{simu_pkg::OP_UPDATE, 0, 0, 0, 0, 0, 0, 0, 65536, 0, 0, 0, 0, 0, 0},
		'{simu_pkg::OP_UPDATE, 32'sh80000000, 32'sh80000000, 32'sh80000000,
			32'sh80000000, 32'sh80000000, 32'sh80000000, 31'h7fffffff, 65536,
			32'sh80000000, 32'sh80000000, 1, 0, 0, 0},
		'{simu_pkg::OP_UPDATE, 300000, -300000, -200000, 100000, 9000000, -7000000,
			131072, 32768, 65536, 65536, 131072, 0, 0, 0},
		'{simu_pkg::OP_UPDATE, 0, 65536, 65536, 0, 0, 65536, 31'h00010000, 65535, 0, 0,
			31'h40000000, 0, 0, 0},
		'{simu_pkg::OP_UPDATE, -65536, 0, 0, -65536, -65536, 0, 31'h00100000, 1, -500,
			500, 31'h00000001, 0, 0, 0},
		'{simu_pkg::OP_UPDATE, 12, 34, 56, 78, 90, 12, 31'h00000100, 100, 7, 9,
			31'h00000100, 0, 0, 0}
	};

	// output side: stall pattern of its own, plus one long hold-off on request
	initial begin
		int mode_left;
		int mode;
		out_ready = 1'b0;
		mode_left = 0;
		mode = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode = $urandom_range(0, 2);
					mode_left = $urandom_range(20, 120);
				end
				mode_left--;
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= 1'($urandom_range(0, 1));
					default: out_ready <= ($urandom_range(0, 4) == 0);
				endcase
			end
		end
	end

	// check each output word against the oldest expectation; watch for hangs
	always @(posedge clk) begin
		simu_pkg::res_t e;
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("sea_ice_momentum_node_update_test: errors");
				$finish;
			end
		end
		if (out_valid && out_ready) begin
			if (vel_due.size() == 0) begin
				$error("unexpected word: new_vel_x %0d new_vel_y %0d",
					new_vel_x, new_vel_y);
				mismatches++;
			end else begin
				e = vel_due.pop_front();
				if (new_vel_x !== e.vx) begin
					$error("new_vel_x expected %0d actual %0d", e.vx, new_vel_x);
					mismatches++;
				end
				if (new_vel_y !== e.vy) begin
					$error("new_vel_y expected %0d actual %0d", e.vy, new_vel_y);
					mismatches++;
				end
				if (divide_fault !== e.fault) begin
					$error("divide_fault expected %0d actual %0d", e.fault, divide_fault);
					mismatches++;
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
		in_valid = 1'b0; opcode = simu_pkg::OP_CAPTURE;
		vel_x = 0; vel_y = 0; ocean_x = 0; ocean_y = 0; wind_x = 0; wind_y = 0;
		ice_thickness = 0; ice_cover = 0; stress_div_x = 0; stress_div_y = 0;
		node_mass = 0;
		rho_q = simu_pkg::ICE_DENSITY_RST; fo_q = 0; fa_q = 0; fc_q = 0;
		dt_q = simu_pkg::TIME_STEP_RST; beta_q = 0; nodes_q = simu_pkg::NODE_COUNT_RST;
		node_ptr = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed pass over four nodes
		write_all(simu_pkg::ICE_DENSITY_RST, 32'h0100_0000, 32'h0010_0000,
			32'h0000_1000, simu_pkg::TIME_STEP_RST, 32'h0000_8000, 32'd4);
		foreach (dir_tab[i]) send_word(dir_tab[i]);
		drain();

		// random phases, extremes first; the hold-off phase runs long to fill up
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: write_all(0, 0, 0, 0, 32'd1, 0, 32'd1);
				1: write_all('1, '1, '1, '1, '1, '1, 32'd65536);
				2: write_all($urandom, $urandom, $urandom, $urandom,
					$urandom_range(1, 32'hffff_ffff), $urandom, 32'd0);
				3: write_all($urandom, $urandom, $urandom, $urandom,
					$urandom_range(1, 32'h0004_0000), $urandom, 32'h0001_ffff);
				default: write_all($urandom_range(0, 32'h0400_0000), $urandom,
					$urandom, $urandom_range(0, 32'h0010_0000),
					$urandom_range(1, 32'h000a_0000), $urandom_range(0, 32'h0004_0000),
					{$urandom_range(0, 1) ? 15'h0 : 15'($urandom),
					17'($urandom_range(2, 24))});
			endcase
			if (p == HOLD_PHASE) begin
				hold_req = 1'b1;
				for (int k = 0; k < HOLD_PHASE_WORDS; k++) send_word(random_word());
			end else begin
				for (int k = 0; k < PHASE_WORDS; k++) send_word(random_word());
			end
			drain();
		end

		if (mismatches == 0 && vel_due.size() == 0)
			$display("sea_ice_momentum_node_update_test: clean");
		else
			$display("sea_ice_momentum_node_update_test: errors");
		$finish;
	end

endmodule

>>> filelist.f
sv/simu_pkg.sv
sv/simu_ram.sv
sv/simu_dly.sv
sv/simu_mul.sv
sv/simu_div.sv
sv/simu_hyp.sv
sv/simu_obuf.sv
sv/sea_ice_momentum_node_update.sv
sv/simu_chk.sv
tb/sea_ice_momentum_node_update_test.sv
